// File: src/ppfs_pkg.sv
// ----------------------------------------------------------------------------
// ppfs_pkg: shared types and constants of the pixel predictor filter select
// Field widths, reset values and the filter codes used by the datapath and
// by its port checker.
// ----------------------------------------------------------------------------
package ppfs_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// Row width register
	localparam int WIDTH_BITS = 11;
	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd1024;

	// Result fields
	localparam int RES_BITS  = 10;
	localparam int FILT_BITS = 3;
	localparam int NUM_FILT  = 5;

	typedef enum logic [FILT_BITS-1:0] {
		FILT_NONE  = 3'd0,
		FILT_LEFT  = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_GRAD  = 3'd4
	} filt_t;

endpackage

// File: src/pixel_predictor_filter_select.sv
// ----------------------------------------------------------------------------
// pixel_predictor_filter_select: adaptive prediction filter choice per pixel
// Forms the none, left, up, average and gradient predictions for each pixel
// of a raster stream and reports the one with the smallest residual.
// ----------------------------------------------------------------------------
// Throughput is one pixel per clock unless a stalled result holds stage 1:
// the request is captured together with a synchronous read of the
// line buffer (one entry per column, one read and one write port), and the
// predictor compare and select then fill the result register. The address of
// the upper neighbour is worked out from the column of the pixel ahead, and a
// same-cycle write to that column is forwarded, so rows of any width back to
// back need no gaps. The line buffer holds no reset value: the first row of
// each frame (frame_start high) ignores what it reads. image_width may only be
// written while no request is in flight; zero acts as one and values above
// MAX_WIDTH act as MAX_WIDTH.
module pixel_predictor_filter_select #(
	parameter int MAX_WIDTH  = ppfs_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = ppfs_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ppfs_pkg::WIDTH_BITS-1:0]   image_width,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [PIXEL_BITS-1:0]             pixel_value,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ppfs_pkg::FILT_BITS-1:0]    filter_type,
	output logic signed [ppfs_pkg::RES_BITS-1:0] residual,
	output logic                              row_end
);
	import ppfs_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
	localparam int PW   = PIXEL_BITS + 2;
	localparam int RW   = PIXEL_BITS + 3;
	localparam int SW   = (RW > RES_BITS) ? RW : RES_BITS;
	localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);
	localparam logic signed [SW-1:0] RES_MAX = SW'((1 << (RES_BITS - 1)) - 1);
	localparam logic signed [SW-1:0] RES_MIN = SW'(-(1 << (RES_BITS - 1)));

	logic [WIDTH_BITS-1:0] image_width_q;

	logic                  s1_valid_q;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic                  frame_start_s1;
	logic [PIXEL_BITS-1:0] mem_rd_s1;
	logic [PIXEL_BITS-1:0] byp_pix_s1;
	logic                  byp_s1;

	logic [PIXEL_BITS-1:0] line_store [MAX_WIDTH];

	logic [CW-1:0]         column_index_q;
	logic [PIXEL_BITS-1:0] left_q;
	logic [PIXEL_BITS-1:0] upper_left_q;
	logic                  first_row_q;

	logic                  out_valid_q;
	filt_t                 filt_q;
	logic [RES_BITS-1:0]   res_q;
	logic                  row_end_q;

	logic                  in_accept;
	logic                  s1_adv;
	logic                  s1_fire;
	logic [CW-1:0]         col;
	logic [CW:0]           col_p1;
	logic                  last;
	logic [CW-1:0]         col_next;
	logic [CW-1:0]         rd_addr;
	logic                  first_row;
	logic [PIXEL_BITS-1:0] up_raw;
	logic signed [PW-1:0]  pa, pb, pc;
	logic signed [PW-1:0]  pred [NUM_FILT];
	logic signed [RW-1:0]  res [NUM_FILT];
	logic signed [RW-1:0]  mag [NUM_FILT];
	filt_t                 best_f;
	logic signed [RW-1:0]  best_res;
	logic signed [RW-1:0]  best_mag;
	logic signed [SW-1:0]  res_ext;
	logic signed [SW-1:0]  res_sat;

	// Handshake: stage 1 moves on when the result register is free or draining
	assign s1_adv    = !out_valid_q || !out_stall;
	assign s1_fire   = s1_valid_q && s1_adv;
	assign in_stall  = s1_valid_q && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// Column of the pixel in stage 1 and the end-of-row decision
	assign col       = frame_start_s1 ? '0 : column_index_q;
	assign first_row = frame_start_s1 || first_row_q;
	assign col_p1    = {1'b0, col} + (CW + 1)'(1);
	assign last      = (col == LAST_COL) ||
	                   (CMPW'(col_p1) >= CMPW'(image_width_q));
	assign col_next  = last ? '0 : col_p1[CW-1:0];

	// Read address for the incoming request: the column it will occupy
	always_comb begin
		if (frame_start) begin
			rd_addr = '0;
		end else if (s1_valid_q) begin
			rd_addr = col_next;
		end else begin
			rd_addr = column_index_q;
		end
	end

	// Row width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_write) begin
			image_width_q <= image_width;
		end
	end

	// Line buffer: write the retiring pixel, read the upper neighbour of the next
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			line_store[col] <= pix_s1;
		end
		if (in_accept) begin
			mem_rd_s1 <= line_store[rd_addr];
		end
	end

	// Capture the request and the forwarding case
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1         <= pixel_value;
			frame_start_s1 <= frame_start;
			byp_s1         <= s1_fire && (col == rd_addr);
			byp_pix_s1     <= pix_s1;
		end
	end

	assign up_raw = byp_s1 ? byp_pix_s1 : mem_rd_s1;

	// Neighbours, zero outside the image
	assign pa = (col != '0) ? {2'b00, left_q} : '0;
	assign pb = first_row ? '0 : {2'b00, up_raw};
	assign pc = (!first_row && col != '0) ? {2'b00, upper_left_q} : '0;

	// Five predictions
	assign pred[0] = '0;
	assign pred[1] = pa;
	assign pred[2] = pb;
	assign pred[3] = (pa + pb) >>> 1;
	assign pred[4] = pa + pb - pc;

	// Residuals and magnitudes
	always_comb begin
		for (int f = 0; f < NUM_FILT; f++) begin
			res[f] = $signed({3'b000, pix_s1}) - RW'(pred[f]);
			mag[f] = (res[f] < 0) ? -res[f] : res[f];
		end
	end

	// Pick the smallest magnitude, lower filter number wins a tie
	always_comb begin
		best_f   = FILT_NONE;
		best_res = res[0];
		best_mag = mag[0];
		for (int f = 1; f < NUM_FILT; f++) begin
			if (mag[f] < best_mag) begin
				best_f   = filt_t'(FILT_BITS'(f));
				best_res = res[f];
				best_mag = mag[f];
			end
		end
	end

	// Clamp the residual to the output field
	assign res_ext = SW'(best_res);
	always_comb begin
		priority if (res_ext > RES_MAX) begin
			res_sat = RES_MAX;
		end else if (res_ext < RES_MIN) begin
			res_sat = RES_MIN;
		end else begin
			res_sat = res_ext;
		end
	end

	// Advance the row state as each pixel retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_index_q <= '0;
			left_q         <= '0;
			upper_left_q   <= '0;
			first_row_q    <= 1'b1;
		end else if (s1_fire) begin
			column_index_q <= col_next;
			left_q         <= last ? '0 : pix_s1;
			upper_left_q   <= last ? '0 : up_raw;
			first_row_q    <= last ? 1'b0 : first_row;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			filt_q    <= best_f;
			res_q     <= res_sat[RES_BITS-1:0];
			row_end_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign filter_type = filt_q;
	assign residual    = $signed(res_q);
	assign row_end     = row_end_q;

endmodule

// File: src/ppfs_checker.sv
// ----------------------------------------------------------------------------
// ppfs_checker: port checks for the pixel predictor filter select
// Watches the request and result handshakes and the result fields.
// ----------------------------------------------------------------------------
module ppfs_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_stall,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [ppfs_pkg::FILT_BITS-1:0]        filter_type,
	input logic signed [ppfs_pkg::RES_BITS-1:0]  residual,
	input logic                                  row_end
);
	import ppfs_pkg::*;

	// Only five filters exist
	a_filt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (filter_type <= FILT_GRAD))
		else $error("filter_type out of range");

	// With no prediction the residual is the pixel itself
	a_none_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && filter_type == FILT_NONE) |-> (residual >= 0))
		else $error("negative residual for filter none");

	// Back pressure on requests only comes from a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a stalled result");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(filter_type) && $stable(residual) && $stable(row_end)))
		else $error("stalled result changed");

endmodule

bind pixel_predictor_filter_select ppfs_checker u_ppfs_checker (.*);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for pixel_predictor_filter_select
// Streams raster pixels through the block under random input gaps and output
// stalls. Each accepted request is run through a local copy of the
// predictor, and the filter choice, residual and row end are checked in order.
// Row widths cover zero, one, small and mid-size rows, full and oversized rows.
// ----------------------------------------------------------------------------
module tb_top;
	import ppfs_pkg::*;

	localparam int MAX_W       = MAX_WIDTH_DEF;
	localparam int PIX_BITS    = PIXEL_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int SHOW_ERRORS = 10;

	typedef struct packed {
		filt_t                      ft;
		logic signed [RES_BITS-1:0] res;
		logic                       row_last;
	} pix_result_t;

	typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_BINARY, PIX_RAMP} pix_mode_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_write   = 1'b0;
	logic [WIDTH_BITS-1:0] image_width = WIDTH_RESET;
	logic                  in_valid    = 1'b0;
	logic [PIX_BITS-1:0]   pixel_value = '0;
	logic                  frame_start = 1'b0;
	logic                  out_stall   = 1'b0;
	wire                   in_stall;
	wire                   out_valid;
	wire [FILT_BITS-1:0]   filter_type;
	wire signed [RES_BITS-1:0] residual;
	wire                   row_end;

	// Predictor state: previous row, neighbours, position and row width
	logic [PIX_BITS-1:0]   line_buf [MAX_W];
	logic [PIX_BITS-1:0]   left_pix;
	logic [PIX_BITS-1:0]   upleft_pix;
	int                    col_idx;
	bit                    first_row;
	logic [WIDTH_BITS-1:0] row_width;

	pix_result_t pending_results [$];
	bit          need_frame;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_trigger;
	int          hold_left;
	int          err_count;
	int          sent_count;
	int          checked_count;
	int          row_end_count;
	int          cycle_count;

	pixel_predictor_filter_select dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.image_width (image_width),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_value (pixel_value),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filter_type (filter_type),
		.residual    (residual),
		.row_end     (row_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Zero acts as one, oversized rows clip to the line buffer depth
	function automatic int eff_width(input logic [WIDTH_BITS-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_W)
			return MAX_W;
		return int'(w);
	endfunction

	// Pick the filter with the smallest residual and advance the raster position
	function automatic pix_result_t predict_pixel(input logic [PIX_BITS-1:0] pix, input logic fs);
		int                  w, ccol, a, b, c, pred, r, m, best_abs, best_res;
		logic [PIX_BITS-1:0] up;
		filt_t               best;
		pix_result_t         o;
		w = eff_width(row_width);
		if (fs) begin
			col_idx    = 0;
			first_row  = 1'b1;
			left_pix   = '0;
			upleft_pix = '0;
		end
		ccol = (col_idx >= MAX_W) ? MAX_W - 1 : col_idx;
		up   = line_buf[ccol];
		a    = (ccol > 0) ? int'(left_pix) : 0;
		b    = first_row ? 0 : int'(up);
		c    = (!first_row && ccol > 0) ? int'(upleft_pix) : 0;
		best     = FILT_NONE;
		best_abs = 0;
		best_res = 0;
		for (int f = 0; f < NUM_FILT; f++) begin
			case (filt_t'(f))
				FILT_LEFT: pred = a;
				FILT_UP:   pred = b;
				FILT_AVG:  pred = (a + b) / 2;
				FILT_GRAD: pred = a + b - c;
				default:   pred = 0;
			endcase
			r = int'(pix) - pred;
			m = (r < 0) ? -r : r;
			// strict compare keeps ties on the lower filter
			if (f == 0 || m < best_abs) begin
				best_abs = m;
				best_res = r;
				best     = filt_t'(f);
			end
		end
		if (best_res > 511)
			best_res = 511;
		if (best_res < -512)
			best_res = -512;
		o.ft       = best;
		o.res      = best_res[RES_BITS-1:0];
		o.row_last = (ccol + 1 >= w);

		upleft_pix     = up;
		line_buf[ccol] = pix;
		left_pix       = pix;
		if (o.row_last) begin
			col_idx    = 0;
			first_row  = 1'b0;
			left_pix   = '0;
			upleft_pix = '0;
		end else begin
			col_idx = ccol + 1;
		end
		return o;
	endfunction

	// Offer one request after a random gap, hold it until accepted
	task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic fs);
		logic fs_eff;
		fs_eff = fs | need_frame;
		need_frame = 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= pix;
		frame_start <= fs_eff;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(predict_pixel(pix, fs_eff));
		sent_count++;
	endtask

	// Drop valid and wait until every expected result has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the row width while idle; a wider row starts a new frame
	task automatic write_width(input logic [WIDTH_BITS-1:0] w);
		settle();
		if (eff_width(w) > eff_width(row_width))
			need_frame = 1'b1;
		cfg_write   <= 1'b1;
		image_width <= w;
		@(posedge clk);
		row_width = w;
		cfg_write <= 1'b0;
	endtask

	// A few pixels at the reset width, starting a frame
	task automatic test_reset_width();
		logic [PIX_BITS-1:0] seq [6];
		seq = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
		send_idle_pct = 21;
		recv_idle_pct = 57;
		foreach (seq[i])
			send_pixel(seq[i], 1'b0);
	endtask

	// Narrow the row behind the current column, then rows of extremes and ramps
	task automatic test_width_lowered();
		logic [PIX_BITS-1:0] seq [17];
		seq = '{8'd255,
			8'd0,   8'd255, 8'd0,   8'd255,
			8'd255, 8'd255, 8'd0,   8'd0,
			8'd10,  8'd20,  8'd30,  8'd40,
			8'd200, 8'd100, 8'd50,  8'd25};
		write_width(11'd4);
		foreach (seq[i])
			send_pixel(seq[i], 1'b0);
	endtask

	// Width zero and one, then an oversized register value over a full row
	task automatic test_width_edges();
		write_width(11'd0);
		repeat (3) send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
		write_width(11'd1);
		repeat (3) send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
		write_width(11'h7FF);
		repeat (MAX_W + 2) send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
	endtask

	// Hold the output off for a long stretch while requests keep coming
	task automatic test_output_hold();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_width(11'd8);
		hold_trigger = 1'b1;
		repeat (40) send_pixel(PIX_BITS'($urandom_range(0, 255)), 1'b0);
	endtask

	// Frames of random width and texture, with stray frame starts
	task automatic run_random(input int n_items, input int s_idle, input int r_idle);
		int        done, w, rows, step, row, col, p;
		pix_mode_t mode;
		logic      fs;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		done = 0;
		while (done < n_items) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			write_width(w[WIDTH_BITS-1:0]);
			rows = $urandom_range(2, 6);
			mode = pix_mode_t'($urandom_range(0, 3));
			step = $urandom_range(0, 9);
			p    = $urandom_range(0, 255);
			for (row = 0; row < rows && done < n_items; row++) begin
				for (col = 0; col < w && done < n_items; col++) begin
					case (mode)
						PIX_NOISE:  p = $urandom_range(0, 255);
						PIX_SMOOTH: p = p + int'($urandom_range(0, 8)) - 4;
						PIX_BINARY: p = $urandom_range(0, 1) ? 255 : 0;
						default:    p = (col * step + row * 5 + int'($urandom_range(0, 2))) % 256;
					endcase
					if (p < 0)
						p = 0;
					if (p > 255)
						p = 255;
					// open each frame cleanly, now and then break one with a stray start
					fs = (row == 0 && col == 0) || ($urandom_range(0, 99) == 0);
					send_pixel(p[PIX_BITS-1:0], fs);
					done++;
				end
			end
		end
	endtask

	// Output side: long hold on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_trigger) begin
			hold_left    = HOLD_CYCLES;
			hold_trigger = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		pix_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			checked_count++;
			if (row_end)
				row_end_count++;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= SHOW_ERRORS)
					$display("result with nothing pending: filter %0d residual %0d row_end %0b",
						filter_type, residual, row_end);
			end else begin
				want = pending_results.pop_front();
				if (filter_type !== want.ft || residual !== want.res ||
						row_end !== want.row_last) begin
					err_count++;
					if (err_count <= SHOW_ERRORS)
						$display("result %0d: want %0d/%0d/%0b, got %0d/%0d/%0b",
							checked_count, want.ft, $signed(want.res), want.row_last,
							filter_type, residual, row_end);
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_W; i++)
			line_buf[i] = '0;
		left_pix      = '0;
		upleft_pix    = '0;
		col_idx       = 0;
		first_row     = 1'b1;
		row_width     = WIDTH_RESET;
		need_frame    = 1'b1;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_trigger  = 1'b0;
		hold_left     = 0;
		err_count     = 0;
		sent_count    = 0;
		checked_count = 0;
		row_end_count = 0;
		cycle_count   = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_width_lowered();
		test_width_edges();
		run_random(25, 21, 57);
		run_random(25, 57, 21);
		test_output_hold();
		run_random(25, 0, 0);

		settle();
		repeat (8) @(posedge clk);

		$display("%0d pixel requests, %0d results checked, %0d row ends", sent_count,
			checked_count, row_end_count);
		$display("widths 0, 1, 1..64, 1024 and 2047, lowered mid-row, stray frame starts");
		if (err_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
